### sv/affine_transform_composer_top_defines.svh
// Assertion macros for the affine transform composer checker.
// Needs a signal named clk and an active-low reset rst_n in the using scope.
`ifndef AFFINE_TRANSFORM_COMPOSER_TOP_DEFINES_SVH
`define AFFINE_TRANSFORM_COMPOSER_TOP_DEFINES_SVH

// same-cycle implication
`define ATC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atc check failed");

// next-cycle implication
`define ATC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atc check failed");

`endif

### sv/atc_pkg.sv
// Shared constants, types and tables of the affine transform composer.
// No dependencies.
package atc_pkg;

    localparam int WORD_BITS    = 48;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 26;
    localparam int ACTION_BITS  = 3;
    localparam int CV_BITS      = 34;  // CORDIC vector and angle width
    localparam int HALF_BITS    = WORD_BITS / 2;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int CNT_BITS     = 5;
    localparam logic signed [CV_BITS-1:0] CORDIC_GAIN = CV_BITS'(652032874);

    // action codes
    localparam logic [ACTION_BITS-1:0] ACT_ROTATE    = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_TRANSLATE = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_SCALE     = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_SHEAR     = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_MIRROR    = 3'd4;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                cordic_step;
        logic                cordic_finish;
        logic                mul_load;
        logic                mul_acc;
        logic                mul_round;
        logic                elem_sum;
        logic                elem_add;
        logic                commit;
        logic [2:0]          elem;
        logic                k;
        logic [1:0]          part;
        logic [CNT_BITS-1:0] step;
    } atc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rotate;
        logic active;
    } atc_stat_t;

    // atan(2^-i) in degrees, Q.24
    function automatic logic signed [CV_BITS-1:0] atc_atan(input logic [CNT_BITS-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            default: v = 32'd0;
        endcase
        return CV_BITS'(v);
    endfunction

endpackage

### sv/atc_if.sv
// Valid/ready channel interfaces for the composer input and result items.
// Depends on atc_pkg.
interface atc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [atc_pkg::ACTION_BITS-1:0]       action;
    logic signed [atc_pkg::ANGLE_BITS-1:0] angle;
    atc_pkg::word_t                        first_value;
    atc_pkg::word_t                        second_value;

    modport source (output valid, action, angle, first_value, second_value, input ready);
    modport sink (input valid, action, angle, first_value, second_value, output ready);
endinterface

interface atc_out_if;
    logic           valid;
    logic           ready;
    atc_pkg::word_t m_row0_col0;
    atc_pkg::word_t m_row0_col1;
    atc_pkg::word_t m_row0_col2;
    atc_pkg::word_t m_row1_col0;
    atc_pkg::word_t m_row1_col1;
    atc_pkg::word_t m_row1_col2;

    modport source (output valid, m_row0_col0, m_row0_col1, m_row0_col2,
                    m_row1_col0, m_row1_col1, m_row1_col2, input ready);
    modport sink (input valid, m_row0_col0, m_row0_col1, m_row0_col2,
                  m_row1_col0, m_row1_col1, m_row1_col2, output ready);
endinterface

### sv/atc_ctrl.sv
// Sequencer of the composer: CORDIC steps, product parts and element updates.
// Depends on atc_pkg.
module atc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    input  atc_pkg::atc_stat_t  stat,
    output atc_pkg::atc_cmd_t   cmd,
    output logic                in_ready,
    output logic                out_valid
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CORDIC = 4'd2;
    localparam logic [3:0] S_CFIN   = 4'd3;
    localparam logic [3:0] S_MLOAD  = 4'd4;
    localparam logic [3:0] S_MACC   = 4'd5;
    localparam logic [3:0] S_MRND   = 4'd6;
    localparam logic [3:0] S_MSUM   = 4'd7;
    localparam logic [3:0] S_MADD   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]                   state_reg, state_next;
    logic [atc_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [2:0]                   elem_reg, elem_next;
    logic                         k_reg, k_next;
    logic [1:0]                   part_reg, part_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         last_elem, col2;

    assign last_elem = (elem_reg == 3'd5);
    assign col2      = (elem_reg == 3'd2) || (elem_reg == 3'd5);

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        elem_next      = elem_reg;
        k_next         = k_reg;
        part_next      = part_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.elem       = elem_reg;
        cmd.k          = k_reg;
        cmd.part       = part_reg;
        cmd.step       = cnt_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next  = '0;
                elem_next = '0;
                k_next    = 1'b0;
                if (!stat.active)
                    state_next = S_DONE;
                else if (stat.rotate)
                    state_next = S_CORDIC;
                else
                    state_next = S_MLOAD;
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == atc_pkg::CNT_BITS'(atc_pkg::CORDIC_STEPS - 1))
                    state_next = S_CFIN;
            end
            S_CFIN:
            begin
                cmd.cordic_finish = 1'b1;
                state_next        = S_MLOAD;
            end
            S_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                part_next    = '0;
                state_next   = S_MACC;
            end
            S_MACC:
            begin
                cmd.mul_acc = 1'b1;
                part_next   = part_reg + 1'b1;
                if (part_reg == 2'd3)
                    state_next = S_MRND;
            end
            S_MRND:
            begin
                cmd.mul_round = 1'b1;
                if (!k_reg)
                begin
                    k_next     = 1'b1;
                    state_next = S_MLOAD;
                end
                else
                begin
                    state_next = S_MSUM;
                end
            end
            S_MSUM:
            begin
                cmd.elem_sum = 1'b1;
                k_next       = 1'b0;
                if (col2)
                    state_next = S_MADD;
                else
                begin
                    elem_next  = elem_reg + 1'b1;
                    state_next = S_MLOAD;
                end
            end
            S_MADD:
            begin
                cmd.elem_add = 1'b1;
                elem_next    = elem_reg + 1'b1;
                state_next   = last_elem ? S_DONE : S_MLOAD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            elem_reg      <= '0;
            k_reg         <= 1'b0;
            part_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            elem_reg      <= elem_next;
            k_reg         <= k_next;
            part_reg      <= part_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### sv/atc_datapath.sv
// Datapath of the composer: angle folding, CORDIC, shared multiplier,
// saturating adders, matrix and result registers. Depends on atc_pkg.
module atc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  atc_pkg::atc_cmd_t                     cmd,
    output atc_pkg::atc_stat_t                    stat,
    input  logic [atc_pkg::ACTION_BITS-1:0]       action,
    input  logic signed [atc_pkg::ANGLE_BITS-1:0] angle,
    input  atc_pkg::word_t                        first_value,
    input  atc_pkg::word_t                        second_value,
    output atc_pkg::word_t                        res [6]
);

    localparam int W  = atc_pkg::WORD_BITS;
    localparam int F  = atc_pkg::FRAC_BITS;
    localparam int H  = atc_pkg::HALF_BITS;
    localparam int P  = atc_pkg::PROD_BITS;
    localparam int CV = atc_pkg::CV_BITS;
    localparam int AB = 28;  // angle reduction width
    localparam logic signed [AB-1:0] A_FULL    = AB'(360 * 65536);
    localparam logic signed [AB-1:0] A_HALF    = AB'(180 * 65536);
    localparam logic signed [AB-1:0] A_QUARTER = AB'(90 * 65536);
    localparam atc_pkg::word_t ONE      = atc_pkg::word_t'(1) <<< F;
    localparam atc_pkg::word_t WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam atc_pkg::word_t WORD_MIN = {1'b1, {(W-1){1'b0}}};

    logic [atc_pkg::ACTION_BITS-1:0] action_reg;
    atc_pkg::word_t                  xv_reg, yv_reg, c_reg, s_reg;
    logic signed [CV-1:0]            x_reg, y_reg, z_reg;
    logic                            flip_reg;
    atc_pkg::word_t                  m_reg [6];
    atc_pkg::word_t                  n_reg [6];
    atc_pkg::word_t                  p_reg [2];
    atc_pkg::word_t                  res_reg [6];
    logic [W-1:0]                    ua_reg, ub_reg;
    logic                            neg_reg;
    logic [P-1:0]                    acc_reg;

    // saturating add of two words
    function automatic atc_pkg::word_t sat_add(input atc_pkg::word_t a, input atc_pkg::word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? WORD_MIN : WORD_MAX;
        return s[W-1:0];
    endfunction

    // one element of the elementary transform
    function automatic atc_pkg::word_t t_elem(input logic [2:0] idx);
        atc_pkg::word_t t0, t1, t2, t3, t4, t5, r;
        t0 = '0; t1 = '0; t2 = '0; t3 = '0; t4 = '0; t5 = '0;
        case (action_reg)
            atc_pkg::ACT_ROTATE:
            begin
                t0 = c_reg; t1 = s_reg; t3 = -s_reg; t4 = c_reg;
            end
            atc_pkg::ACT_TRANSLATE:
            begin
                t0 = ONE; t2 = xv_reg; t4 = ONE; t5 = yv_reg;
            end
            atc_pkg::ACT_SCALE:
            begin
                t0 = xv_reg; t4 = yv_reg;
            end
            atc_pkg::ACT_SHEAR:
            begin
                t0 = ONE; t1 = xv_reg; t3 = yv_reg; t4 = ONE;
            end
            atc_pkg::ACT_MIRROR:
            begin
                t0 = ONE; t4 = -ONE;
            end
            default:
            begin
                t0 = '0;
            end
        endcase
        case (idx)
            3'd0:    r = t0;
            3'd1:    r = t1;
            3'd2:    r = t2;
            3'd3:    r = t3;
            3'd4:    r = t4;
            default: r = t5;
        endcase
        return r;
    endfunction

    // angle reduction into [-90, 90] degrees
    logic signed [AB-1:0] r0, r1, r2, r3, r4;
    logic                 flip_in;
    always_comb
    begin
        r0 = AB'(angle);
        if (r0 >= A_FULL)
            r1 = r0 - A_FULL;
        else if (r0 <= -A_FULL)
            r1 = r0 + A_FULL;
        else
            r1 = r0;
        r2 = (r1 < 0) ? r1 + A_FULL : r1;
        r3 = (r2 > A_HALF) ? r2 - A_FULL : r2;
        flip_in = 1'b0;
        if (r3 > A_QUARTER)
        begin
            r4 = r3 - A_HALF;
            flip_in = 1'b1;
        end
        else if (r3 < -A_QUARTER)
        begin
            r4 = r3 + A_HALF;
            flip_in = 1'b1;
        end
        else
        begin
            r4 = r3;
        end
    end

    // CORDIC rounding to the word format
    logic signed [CV-1:0] xr, yr;
    assign xr = (x_reg + (CV'(1) <<< (29 - F))) >>> (30 - F);
    assign yr = (y_reg + (CV'(1) <<< (29 - F))) >>> (30 - F);

    // operand selection for the shared multiplier
    logic           row;
    logic [1:0]     col;
    logic [2:0]     a_idx, b_idx;
    atc_pkg::word_t a_op, b_op;
    always_comb
    begin
        row   = (cmd.elem >= 3'd3);
        col   = row ? 2'(cmd.elem - 3'd3) : cmd.elem[1:0];
        a_idx = (row ? 3'd3 : 3'd0) + {2'b00, cmd.k};
        b_idx = (cmd.k ? 3'd3 : 3'd0) + {1'b0, col};
        a_op  = m_reg[a_idx];
        b_op  = t_elem(b_idx);
    end

    // partial product of two half-words
    logic [H-1:0]   pa, pb;
    logic [2*H-1:0] pp;
    logic [P-1:0]   pp_sh;
    assign pa    = cmd.part[1] ? ua_reg[W-1:H] : ua_reg[H-1:0];
    assign pb    = cmd.part[0] ? ub_reg[W-1:H] : ub_reg[H-1:0];
    assign pp    = pa * pb;
    assign pp_sh = P'(pp) << (H * (32'(cmd.part[1]) + 32'(cmd.part[0])));

    // rounding and saturation of the full product
    logic [P-1:0]   rsum, mag, lim;
    atc_pkg::word_t prod;
    always_comb
    begin
        rsum = acc_reg + (P'(1) << (F - 1));
        mag  = rsum >> F;
        lim  = P'(WORD_MAX) + P'(neg_reg);
        if (mag > lim)
            prod = neg_reg ? WORD_MIN : WORD_MAX;
        else
            prod = neg_reg ? -mag[W-1:0] : mag[W-1:0];
    end

    // item registers, CORDIC and multiplier state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            xv_reg     <= first_value;
            yv_reg     <= second_value;
            x_reg      <= atc_pkg::CORDIC_GAIN;
            y_reg      <= '0;
            z_reg      <= CV'(r4) <<< 8;
            flip_reg   <= flip_in;
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[CV-1])
            begin
                x_reg <= x_reg - (y_reg >>> cmd.step);
                y_reg <= y_reg + (x_reg >>> cmd.step);
                z_reg <= z_reg - atc_pkg::atc_atan(cmd.step);
            end
            else
            begin
                x_reg <= x_reg + (y_reg >>> cmd.step);
                y_reg <= y_reg - (x_reg >>> cmd.step);
                z_reg <= z_reg + atc_pkg::atc_atan(cmd.step);
            end
        end
        if (cmd.cordic_finish)
        begin
            c_reg <= flip_reg ? -W'(xr) : W'(xr);
            s_reg <= flip_reg ? -W'(yr) : W'(yr);
        end
        if (cmd.mul_load)
        begin
            ua_reg  <= a_op[W-1] ? -a_op : a_op;
            ub_reg  <= b_op[W-1] ? -b_op : b_op;
            neg_reg <= a_op[W-1] ^ b_op[W-1];
        end
        if (cmd.mul_acc)
        begin
            acc_reg <= (cmd.part == 2'd0) ? pp_sh : acc_reg + pp_sh;
        end
        if (cmd.mul_round)
        begin
            p_reg[cmd.k] <= prod;
        end
        if (cmd.elem_sum)
        begin
            n_reg[cmd.elem] <= sat_add(p_reg[0], p_reg[1]);
        end
        if (cmd.elem_add)
        begin
            n_reg[cmd.elem] <= sat_add(n_reg[cmd.elem], m_reg[cmd.elem]);
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < 6; i++)
                res_reg[i] <= (action_reg <= atc_pkg::ACT_MIRROR) ? n_reg[i] : m_reg[i];
        end
    end

    // matrix state, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                m_reg[i] <= (i == 0 || i == 4) ? ONE : '0;
        end
        else if (cmd.commit && (action_reg <= atc_pkg::ACT_MIRROR))
        begin
            for (int i = 0; i < 6; i++)
                m_reg[i] <= n_reg[i];
        end
    end

    assign stat.rotate = (action_reg == atc_pkg::ACT_ROTATE);
    assign stat.active = (action_reg <= atc_pkg::ACT_MIRROR);
    assign res         = res_reg;

endmodule

### sv/affine_transform_composer_top.sv
// Top level of the 2D affine transform composer.
// Depends on atc_pkg, atc_if, atc_ctrl and atc_datapath.
//
// Usage:
//   in_ch takes one item: action (rotate, translate, scale, shear, mirror),
//   angle in degrees for rotate, and two Q32.16 values. The held matrix is
//   post-multiplied by that transform and out_ch gives the six stored
//   elements after the update, one result item for each input item.
//   Items are handled one at a time; in_ch.ready is high only when idle.
//   An accepted item is decoded; a rotate item then runs the CORDIC steps
//   and a finish step, and every active action runs the matrix update;
//   unused action codes go straight to the result. The next item can be
//   taken in the same cycle as the result goes valid.
//   The update is twelve products on the shared 24x24 multiplier, each
//   made by load, four partial products and round, six sums and two
//   offset adds; the CORDIC runs one step per cycle for rotate.
//   The result sits in an output register; if out_ch stalls, the next item
//   is still taken and worked on, and its result waits until the previous
//   one is taken.
//   Reset sets the matrix to identity and drops out_ch.valid.
module affine_transform_composer_top (
    input logic clk,
    input logic rst_n,
    atc_in_if.sink    in_ch,
    atc_out_if.source out_ch
);

    atc_pkg::atc_cmd_t  cmd;
    atc_pkg::atc_stat_t stat;
    atc_pkg::word_t     res [6];
    logic               in_ready;
    logic               out_valid;

    atc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    atc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (in_ch.action),
        .angle        (in_ch.angle),
        .first_value  (in_ch.first_value),
        .second_value (in_ch.second_value),
        .res          (res)
    );

    // channel wiring
    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = out_valid;
    assign out_ch.m_row0_col0  = res[0];
    assign out_ch.m_row0_col1  = res[1];
    assign out_ch.m_row0_col2  = res[2];
    assign out_ch.m_row1_col0  = res[3];
    assign out_ch.m_row1_col1  = res[4];
    assign out_ch.m_row1_col2  = res[5];

endmodule

### sv/atc_checker.sv
// Port-level checks of the affine transform composer, bound to the top level.
// Depends on atc_pkg and affine_transform_composer_top_defines.svh.
`include "affine_transform_composer_top_defines.svh"

module atc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input atc_pkg::word_t out_m00
);

    // a stalled result stays offered and its first element unchanged
    `ATC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ATC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_m00))

    // one item at a time: busy right after an accept
    `ATC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a new result appears exactly when the block goes idle again
    `ATC_ASSERT_NOW(a_idle_on_result, $rose(out_valid), in_ready)

endmodule

bind affine_transform_composer_top atc_checker u_atc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_m00   (out_ch.m_row0_col0)
);

### sim/affine_transform_composer_top_tb.sv
// Self-checking testbench of the affine transform composer.
// Drives directed and random transform items through the valid/ready
// channels and checks every matrix result. Depends on atc_pkg, atc_if, RTL.
module affine_transform_composer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEP_LIMIT  = 3000000;
    localparam int  RAND_ITEMS  = 1530;
    localparam longint W_MAX    = (64'sd1 <<< (atc_pkg::WORD_BITS - 1)) - 1;
    localparam longint W_MIN    = -W_MAX - 1;
    localparam longint ONE_Q    = 64'sd1 <<< atc_pkg::FRAC_BITS;
    localparam logic [atc_pkg::ACTION_BITS-1:0] ACT_SPARE   = 3'd5;
    localparam logic [atc_pkg::ACTION_BITS-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [atc_pkg::ACTION_BITS-1:0] ACT_SPARE_C = 3'd7;

    typedef struct {
        atc_pkg::word_t e[6];
    } matrix_t;

    // Matrix predictor plus queue of expected matrices
    class matrix_scoreboard;
        longint  mat[6];
        matrix_t pending[$];
        int      errors;

        function new();
            mat = '{ONE_Q, 0, 0, 0, ONE_Q, 0};
            errors = 0;
        endfunction

        // rounded, saturated fixed-point product
        function longint fx_mul(longint a, longint b);
            logic signed [127:0] pa, pb, p;
            logic [127:0] mag;
            logic neg;
            pa = a;
            pb = b;
            p = pa * pb;
            neg = p < 0;
            mag = neg ? -p : p;
            mag = (mag + (128'd1 << (atc_pkg::FRAC_BITS - 1))) >> atc_pkg::FRAC_BITS;
            if (!neg && mag > 128'(W_MAX))
                return W_MAX;
            if (neg && mag > 128'(W_MAX) + 1)
                return W_MIN;
            return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
        endfunction

        function longint fx_add(longint a, longint b);
            longint s;
            s = a + b;
            if (s > W_MAX)
                return W_MAX;
            if (s < W_MIN)
                return W_MIN;
            return s;
        endfunction

        // degree-based CORDIC, folded into [-90, 90]
        function void cordic_deg(longint ang, output longint c, output longint s);
            longint full, half, quarter, r, x, y, z, nx;
            bit flip;
            full = 64'sd360 <<< 16;
            half = 64'sd180 <<< 16;
            quarter = 64'sd90 <<< 16;
            r = ang % full;
            flip = 0;
            x = 652032874;
            y = 0;
            if (r < 0)
                r += full;
            if (r > half)
                r -= full;
            if (r > quarter)
            begin
                r -= half;
                flip = 1;
            end
            else if (r < -quarter)
            begin
                r += half;
                flip = 1;
            end
            z = r * 256;
            for (int i = 0; i < atc_pkg::CORDIC_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'(atc_pkg::atc_atan(atc_pkg::CNT_BITS'(i)));
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'(atc_pkg::atc_atan(atc_pkg::CNT_BITS'(i)));
                end
                x = nx;
            end
            x = (x + (64'sd1 <<< (29 - atc_pkg::FRAC_BITS))) >>> (30 - atc_pkg::FRAC_BITS);
            y = (y + (64'sd1 <<< (29 - atc_pkg::FRAC_BITS))) >>> (30 - atc_pkg::FRAC_BITS);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // accepted input: post-multiply and queue the new matrix
        function void note_input(logic [atc_pkg::ACTION_BITS-1:0] act,
                                 logic signed [atc_pkg::ANGLE_BITS-1:0] ang,
                                 atc_pkg::word_t fv, atc_pkg::word_t sv);
            longint t[6], n[6], c, s, xv, yv;
            matrix_t m;
            bit apply;
            xv = fv;
            yv = sv;
            apply = 1;
            case (act)
                atc_pkg::ACT_ROTATE:
                begin
                    cordic_deg(longint'(ang), c, s);
                    t = '{c, s, 0, -s, c, 0};
                end
                atc_pkg::ACT_TRANSLATE: t = '{ONE_Q, 0, xv, 0, ONE_Q, yv};
                atc_pkg::ACT_SCALE:     t = '{xv, 0, 0, 0, yv, 0};
                atc_pkg::ACT_SHEAR:     t = '{ONE_Q, xv, 0, yv, ONE_Q, 0};
                atc_pkg::ACT_MIRROR:    t = '{ONE_Q, 0, 0, 0, -ONE_Q, 0};
                default:                apply = 0;
            endcase
            if (apply)
            begin
                for (int r = 0; r < 2; r++)
                begin
                    n[r*3]   = fx_add(fx_mul(mat[r*3], t[0]), fx_mul(mat[r*3+1], t[3]));
                    n[r*3+1] = fx_add(fx_mul(mat[r*3], t[1]), fx_mul(mat[r*3+1], t[4]));
                    n[r*3+2] = fx_add(fx_add(fx_mul(mat[r*3], t[2]),
                                             fx_mul(mat[r*3+1], t[5])), mat[r*3+2]);
                end
                mat = n;
            end
            foreach (m.e[i])
                m.e[i] = atc_pkg::word_t'(mat[i]);
            pending.push_back(m);
        endfunction

        function void check_result(matrix_t got);
            matrix_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result item", $time);
                errors++;
                return;
            end
            want = pending.pop_front();
            foreach (want.e[i])
                if (want.e[i] !== got.e[i])
                begin
                    $display("%0t: element %0d expected %0d actual %0d",
                             $time, i, want.e[i], got.e[i]);
                    errors++;
                end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    atc_in_if  in_ch();
    atc_out_if out_ch();

    matrix_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycles;

    affine_transform_composer_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // timeout
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > STEP_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check accepted items, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        matrix_t got;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.e = '{out_ch.m_row0_col0, out_ch.m_row0_col1, out_ch.m_row0_col2,
                          out_ch.m_row1_col0, out_ch.m_row1_col1, out_ch.m_row1_col2};
                board.check_result(got);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic [atc_pkg::ACTION_BITS-1:0] act,
                             logic signed [atc_pkg::ANGLE_BITS-1:0] ang,
                             atc_pkg::word_t fv, atc_pkg::word_t sv);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.angle        <= ang;
        in_ch.first_value  <= fv;
        in_ch.second_value <= sv;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_input(act, ang, fv, sv);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic atc_pkg::word_t rand_word();
        return atc_pkg::word_t'({$urandom, $urandom});
    endfunction

    // factor near one, sometimes far off; shrinks a blown-up matrix
    function automatic atc_pkg::word_t rand_factor();
        longint big;
        big = 0;
        foreach (board.mat[i])
            if (board.mat[i] > big || -board.mat[i] > big)
                big = board.mat[i] < 0 ? -board.mat[i] : board.mat[i];
        if (big > (64'sd1 <<< 40))
            return atc_pkg::word_t'($urandom_range(1, 4096));
        if ($urandom_range(19) == 0)
            return rand_word();
        return atc_pkg::word_t'(longint'($urandom_range(16384, 262144))
                                * ($urandom_range(1) ? 1 : -1));
    endfunction

    function automatic atc_pkg::word_t rand_small();
        if ($urandom_range(19) == 0)
            return rand_word();
        return atc_pkg::word_t'($signed(24'($urandom)));
    endfunction

    task automatic random_item();
        logic [atc_pkg::ACTION_BITS-1:0] act;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            act = atc_pkg::ACT_ROTATE;
        else if (pick < 50)
            act = atc_pkg::ACT_TRANSLATE;
        else if (pick < 68)
            act = atc_pkg::ACT_SCALE;
        else if (pick < 84)
            act = atc_pkg::ACT_SHEAR;
        else if (pick < 94)
            act = atc_pkg::ACT_MIRROR;
        else
            act = atc_pkg::ACTION_BITS'($urandom_range(5, 7));
        case (act)
            atc_pkg::ACT_SCALE:
                send_item(act, atc_pkg::ANGLE_BITS'($urandom), rand_factor(), rand_factor());
            atc_pkg::ACT_SHEAR:
                send_item(act, atc_pkg::ANGLE_BITS'($urandom),
                          atc_pkg::word_t'($signed(18'($urandom))),
                          atc_pkg::word_t'($signed(18'($urandom))));
            default:
                send_item(act, atc_pkg::ANGLE_BITS'($urandom), rand_small(), rand_small());
        endcase
    endtask

    initial
    begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = atc_pkg::ACT_ROTATE;
        in_ch.angle = '0;
        in_ch.first_value = '0;
        in_ch.second_value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: angle folding, every action, spare codes, extremes
        send_item(atc_pkg::ACT_ROTATE, 26'sd0, '0, '0);
        send_item(atc_pkg::ACT_ROTATE, 26'sd90 <<< 16, '0, '0);
        send_item(atc_pkg::ACT_ROTATE, 26'sd180 <<< 16, '0, '0);
        send_item(atc_pkg::ACT_ROTATE, -(26'sd90 <<< 16), '0, '0);
        send_item(atc_pkg::ACT_ROTATE, 26'sd270 <<< 16, '0, '0);
        send_item(atc_pkg::ACT_ROTATE, 26'sd45 <<< 16, '0, '0);
        send_item(atc_pkg::ACT_ROTATE, 26'sd33554431, '0, '0);
        send_item(atc_pkg::ACT_ROTATE, -26'sd33554431 - 26'sd1, '0, '0);
        send_item(atc_pkg::ACT_TRANSLATE, '0, atc_pkg::word_t'(W_MAX), atc_pkg::word_t'(W_MIN));
        send_item(atc_pkg::ACT_TRANSLATE, '0, atc_pkg::word_t'(W_MIN), atc_pkg::word_t'(W_MAX));
        send_item(atc_pkg::ACT_TRANSLATE, '0, atc_pkg::word_t'(-1), atc_pkg::word_t'(-1));
        send_item(atc_pkg::ACT_SCALE, '0, atc_pkg::word_t'(W_MAX), atc_pkg::word_t'(W_MIN));
        send_item(atc_pkg::ACT_SCALE, '0, atc_pkg::word_t'(1), atc_pkg::word_t'(-1));
        send_item(atc_pkg::ACT_SCALE, '0, atc_pkg::word_t'(2), atc_pkg::word_t'(2));
        send_item(atc_pkg::ACT_SHEAR, '0, atc_pkg::word_t'(ONE_Q / 2),
                  atc_pkg::word_t'(-ONE_Q / 4));
        send_item(atc_pkg::ACT_SHEAR, '0, atc_pkg::word_t'(W_MAX), atc_pkg::word_t'(W_MIN));
        send_item(atc_pkg::ACT_SCALE, '0, atc_pkg::word_t'(1), atc_pkg::word_t'(1));
        send_item(atc_pkg::ACT_MIRROR, '0, '0, '0);
        send_item(ACT_SPARE, 26'sd12345, atc_pkg::word_t'(W_MAX), atc_pkg::word_t'(W_MIN));
        send_item(ACT_SPARE_B, '0, '0, '0);
        send_item(ACT_SPARE_C, '0, '0, '0);
        // hold off until the block has caught up
        drain();

        // random: phases of idling on each side
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            case (n / (RAND_ITEMS / 5))
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3:       begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            random_item();
        end

        drain();
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### affine_transform_composer_top.f
+incdir+sv
sv/atc_pkg.sv
sv/atc_if.sv
sv/atc_ctrl.sv
sv/atc_datapath.sv
sv/affine_transform_composer_top.sv
sv/atc_checker.sv
sim/affine_transform_composer_top_tb.sv
